FILE: rtl/core/prc_pkg.sv
// types and constants shared by the progress ramp controller
package prc_pkg;

    localparam int LEVEL_W   = 17;
    localparam int ELAPSED_W = 16;
    localparam int RATE_W    = 16;
    localparam int STEP_W    = RATE_W + ELAPSED_W;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ANIMATE = 3'd1;
    localparam logic [OP_W-1:0] OP_REPEAT  = 3'd2;
    localparam logic [OP_W-1:0] OP_JUMP    = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DISMISSED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FORWARD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REVERSE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTANT   = 2'd1;

    localparam logic [RATE_W-1:0] STEP_RATE_RESET = 16'd656;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [LEVEL_W-1:0]   position;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 bounce;
    } in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [STATUS_W-1:0] phase_status;
        logic                level_changed;
        logic                status_changed;
        logic                running;
    } out_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                repeating;
        logic                bouncing;
        logic                active;
    } flags_t;

endpackage

FILE: rtl/core/prc_step.sv
// next-state and result logic for one command
module prc_step
    import prc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  in_t                    item,
    input  logic [RATE_W-1:0]      step_rate,
    input  logic                   instant,
    input  logic [FRACTION_BITS:0] progress,
    input  logic [FRACTION_BITS:0] goal,
    input  logic [FRACTION_BITS:0] phase,
    input  flags_t                 flags,
    output logic [FRACTION_BITS:0] progress_next,
    output logic [FRACTION_BITS:0] goal_next,
    output logic [FRACTION_BITS:0] phase_next,
    output flags_t                 flags_next,
    output out_t                   result
);

    localparam int PW = FRACTION_BITS + 1;
    localparam int CW = ((PW > STEP_W) ? PW : STEP_W) + 1;
    localparam logic [PW-1:0] ONE_P     = PW'(1) << FRACTION_BITS;
    localparam logic [CW-1:0] ONE_C     = CW'(1) << FRACTION_BITS;
    localparam logic [PW-1:0] WRAP_MASK = ONE_P - PW'(1);
    localparam logic [PW:0]   TWO_P     = (PW+1)'(1) << PW;

    logic [STEP_W-1:0] prod;
    logic [PW-1:0]     step_run;
    logic [PW-1:0]     step_rep;
    logic [PW-1:0]     rep_sum;
    logic [PW-1:0]     rep_phase;
    logic              rep_rev;
    logic [PW-1:0]     rep_level;
    logic              up;
    logic [PW-1:0]     span;
    logic              hit;
    logic [PW-1:0]     run_level;
    logic [PW-1:0]     pos_clamp;

    function automatic logic [STATUS_W-1:0] settle(input logic [PW-1:0] lvl,
                                                   input logic [STATUS_W-1:0] st);
        logic [STATUS_W-1:0] r;
        r = st;
        if (lvl == '0)
            r = ST_DISMISSED;
        else if (lvl >= ONE_P)
            r = ST_COMPLETED;
        else if (st == ST_FORWARD)
            r = ST_COMPLETED;
        else if (st == ST_REVERSE)
            r = ST_DISMISSED;
        return r;
    endfunction

    assign prod = {{(STEP_W-ELAPSED_W){1'b0}}, item.elapsed}
                * {{(STEP_W-RATE_W){1'b0}}, step_rate};

    // single run: step clamped at one
    assign step_run = instant ? ONE_P
                    : ((CW'(prod) > ONE_C) ? ONE_P : prod[PW-1:0]);
    // repeat: step not clamped; without bounce only the bits below the mask matter
    assign step_rep = instant ? ONE_P : prod[PW-1:0];

    assign rep_sum   = phase + step_rep;
    assign rep_phase = flags.bouncing ? rep_sum : (rep_sum & WRAP_MASK);
    assign rep_rev   = flags.bouncing && (rep_phase > ONE_P);
    assign rep_level = PW'(TWO_P - {1'b0, rep_phase});

    assign up        = goal > progress;
    assign span      = up ? (goal - progress) : (progress - goal);
    assign hit       = step_run >= span;
    assign run_level = up ? (progress + step_run) : (progress - step_run);

    assign pos_clamp = (CW'(item.position) > ONE_C) ? ONE_P : PW'(item.position);

    always_comb
    begin
        progress_next = progress;
        goal_next     = goal;
        phase_next    = phase;
        flags_next    = flags;
        case (item.op)
            OP_TICK:
            begin
                if (flags.active)
                begin
                    if (flags.repeating)
                    begin
                        phase_next = rep_phase;
                        if (rep_rev)
                        begin
                            flags_next.status = ST_REVERSE;
                            progress_next     = rep_level;
                        end
                        else
                        begin
                            flags_next.status = ST_FORWARD;
                            progress_next     = rep_phase;
                        end
                    end
                    else if (hit)
                    begin
                        progress_next     = goal;
                        flags_next.active = 1'b0;
                        flags_next.status = settle(goal, flags.status);
                    end
                    else
                    begin
                        progress_next = run_level;
                    end
                end
            end
            OP_ANIMATE:
            begin
                flags_next.repeating = 1'b0;
                goal_next            = pos_clamp;
                if (pos_clamp == progress)
                begin
                    flags_next.active = 1'b0;
                    flags_next.status = settle(progress, flags.status);
                end
                else
                begin
                    flags_next.status = (pos_clamp > progress) ? ST_FORWARD : ST_REVERSE;
                    flags_next.active = 1'b1;
                end
            end
            OP_REPEAT:
            begin
                flags_next.repeating = 1'b1;
                flags_next.bouncing  = item.bounce;
                phase_next           = progress;
                flags_next.status    = ST_FORWARD;
                flags_next.active    = 1'b1;
            end
            OP_JUMP:
            begin
                flags_next.repeating = 1'b0;
                goal_next            = pos_clamp;
                progress_next        = pos_clamp;
                flags_next.active    = 1'b0;
                flags_next.status    = settle(pos_clamp, flags.status);
            end
            OP_STOP:
            begin
                flags_next.repeating = 1'b0;
                goal_next            = progress;
                flags_next.active    = 1'b0;
                flags_next.status    = settle(progress, flags.status);
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

    assign result.level          = LEVEL_W'(progress_next);
    assign result.phase_status   = flags_next.status;
    assign result.level_changed  = progress_next != progress;
    assign result.status_changed = flags_next.status != flags.status;
    assign result.running        = flags_next.active;

endmodule

FILE: rtl/core/progress_ramp_controller.sv
// progress ramp controller top level: input register, step logic, result register
//
// in_valid/in_ready carry one command per transaction (tick, animate to,
// repeat, jump to, stop); out_valid/out_ready return exactly one result per
// command, in order. cfg_valid/cfg_ready write step_rate (index 0) or
// instant (index 1); cfg_ready is always high and writes are meant to land
// while no command is in flight.
// a command accepted into the input register has its result written to the
// result register once that register is free, and out_valid rises with it.
// throughput: one command per cycle while out_ready holds, set by the single
// pass of the 16x16 step multiply, compare and add between the two registers.
// a stalled receiver holds the result register; the input register then
// fills and in_ready drops until out_ready returns.
// reset: progress 0, goal 0, phase 0, dismissed, ticker off,
// step_rate 656, instant 0; no transaction pending on either side.
module progress_ramp_controller
    import prc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = FRACTION_BITS + 1;

    logic [RATE_W-1:0] step_rate_reg;
    logic              instant_reg;
    logic [PW-1:0]     progress_reg;
    logic [PW-1:0]     goal_reg;
    logic [PW-1:0]     phase_reg;
    flags_t            flags_reg;
    in_t               item_reg;
    logic              item_valid_reg;
    out_t              result_reg;
    logic              result_valid_reg;

    logic [PW-1:0]     progress_next;
    logic [PW-1:0]     goal_next;
    logic [PW-1:0]     phase_next;
    flags_t            flags_next;
    out_t              result_next;
    logic              advance;

    assign advance   = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = result_valid_reg;
    assign out_data  = result_reg;
    assign cfg_ready = 1'b1;

    prc_step #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_step (
        .item          (item_reg),
        .step_rate     (step_rate_reg),
        .instant       (instant_reg),
        .progress      (progress_reg),
        .goal          (goal_reg),
        .phase         (phase_reg),
        .flags         (flags_reg),
        .progress_next (progress_next),
        .goal_next     (goal_next),
        .phase_next    (phase_next),
        .flags_next    (flags_next),
        .result        (result_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_rate_reg <= STEP_RATE_RESET;
            instant_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_RATE: step_rate_reg <= RATE_W'(cfg_data);
                CFG_INSTANT:   instant_reg   <= cfg_data[0];
                default:       instant_reg   <= instant_reg;
            endcase
        end
    end

    // ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= '0;
            goal_reg     <= '0;
            phase_reg    <= '0;
            flags_reg    <= '{status: ST_DISMISSED, repeating: 1'b0,
                              bouncing: 1'b0, active: 1'b0};
        end
        else if (advance)
        begin
            progress_reg <= progress_next;
            goal_reg     <= goal_next;
            phase_reg    <= phase_next;
            flags_reg    <= flags_next;
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (out_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (advance)
            result_reg <= result_next;
    end

endmodule
